FILE: sv/tbp_pkg.sv
// Shared types and constants for the tagged buffer pool.
// Used by the slot tracker and by the top level; depends on nothing.
package tbp_pkg;

  // Request codes carried on the input tuser
  localparam logic [1:0] REQ_ACQUIRE     = 2'd0;
  localparam logic [1:0] REQ_RELEASE     = 2'd1;
  localparam logic [1:0] REQ_RELEASE_ALL = 2'd2;

  localparam int ID_W    = 64;
  localparam int CTR_W   = 32;
  localparam int TDATA_W = 208;

  // Per-item result from the slot tracker
  typedef struct packed {
    logic            ok;
    logic [2:0]      slot_index;
    logic [ID_W-1:0] buffer_id;
    logic [3:0]      outstanding;
    logic [3:0]      freed_count;
  } pool_result_t;

  // Which statistics counter an item advances
  typedef struct packed {
    logic acq;
    logic rel;
    logic drop;
    logic bad;
  } stat_event_t;

endpackage

FILE: sv/tagged_buffer_pool_top.sv
// Top level of the tagged buffer pool: input register, slot tracker,
// statistics counters and output register. Depends on tbp_pkg and tbp_slots.
//
// Use: each input item is a request. s_axis_tuser holds the request type
// (acquire, release by id, release all) and s_axis_tdata the id to return.
// Each item yields exactly one result item on the m_axis channel: ok on
// m_axis_tuser, and slot index, buffer id, outstanding count, freed count
// and the four saturating statistics counters in m_axis_tdata.
// The single configuration register, the active slot count, is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Throughput is one item per cycle while the receiver does not stall. An
// item is accepted into the input register, then decided in one parallel
// pass (tag compare, priority encoder over slots) into the output register.
// When the receiver stalls, the result holds and the input register can
// still take one more item; further items wait with s_axis_tready low.
// Synchronous reset frees every slot, sets the tag counter to one,
// clears the statistics and sets the slot count to eight.
module tagged_buffer_pool_top
  import tbp_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,   // slot_count
  // request channel
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ID_W-1:0]    s_axis_tdata,  // release_id
  input  logic [1:0]         s_axis_tuser,  // req_type
  // result channel
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // slot_index[2:0], buffer_id[66:3], outstanding[70:67], freed_count[74:71],
  // acquired_total[106:75], released_total[138:107], dropped_total[170:139],
  // bad_release_total[202:171], zero fill[207:203]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser   // ok
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [3:0]       slot_count;
  logic [CW-1:0]    n_active;

  logic             in_valid;
  logic [1:0]       in_req;
  logic [ID_W-1:0]  in_id;
  logic             advance;

  pool_result_t     res;
  stat_event_t      ev;
  logic [CW-1:0]    rel_amount;

  logic [CTR_W-1:0] acq_total;
  logic [CTR_W-1:0] rel_total;
  logic [CTR_W-1:0] drop_total;
  logic [CTR_W-1:0] bad_total;
  logic [CTR_W-1:0] acq_total_next;
  logic [CTR_W-1:0] rel_total_next;
  logic [CTR_W-1:0] drop_total_next;
  logic [CTR_W-1:0] bad_total_next;

  logic               out_valid;
  logic [TDATA_W-1:0] out_data;
  logic               out_ok;

  function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] v,
                                                input logic [CTR_W-1:0] amt);
    logic [CTR_W:0] sum;
    sum = {1'b0, v} + {1'b0, amt};
    return sum[CTR_W] ? '1 : sum[CTR_W-1:0];
  endfunction

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= 4'd8;
    end else if (cfg_wr_en) begin
      slot_count <= cfg_wr_data;
    end
  end

  // Active slot count, clamped to one and to the pool size
  always_comb begin
    priority if (slot_count == 4'd0) begin
      n_active = CW'(1);
    end else if (32'(slot_count) > MAX_SLOTS) begin
      n_active = CW'(MAX_SLOTS);
    end else begin
      n_active = CW'(slot_count);
    end
  end

  // Handshake: the held item moves on whenever the output register frees
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= s_axis_tuser;
      in_id  <= s_axis_tdata;
    end
  end

  tbp_slots #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .req        (in_req),
    .id         (in_id),
    .n_active   (n_active),
    .result     (res),
    .events     (ev),
    .rel_amount (rel_amount)
  );

  // Statistics after this item
  always_comb begin
    acq_total_next  = ev.acq  ? sat_add(acq_total, CTR_W'(1))  : acq_total;
    drop_total_next = ev.drop ? sat_add(drop_total, CTR_W'(1)) : drop_total;
    bad_total_next  = ev.bad  ? sat_add(bad_total, CTR_W'(1))  : bad_total;
    rel_total_next  = ev.rel
                    ? sat_add(rel_total, {{(CTR_W-CW){1'b0}}, rel_amount})
                    : rel_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acq_total  <= '0;
      rel_total  <= '0;
      drop_total <= '0;
      bad_total  <= '0;
    end else if (advance) begin
      acq_total  <= acq_total_next;
      rel_total  <= rel_total_next;
      drop_total <= drop_total_next;
      bad_total  <= bad_total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ok   <= res.ok;
      out_data <= {5'b00000, bad_total_next, drop_total_next, rel_total_next,
                   acq_total_next, res.freed_count, res.outstanding,
                   res.buffer_id, res.slot_index};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_ok;

endmodule

FILE: sv/tbp_slots.sv
// Slot tracker: held flags, tags, tag counter and held count of the pool.
// Depends on tbp_pkg for request codes and the result and event structs.
module tbp_slots
  import tbp_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [1:0]                           req,
  input  logic [ID_W-1:0]                      id,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]       n_active,
  output pool_result_t                         result,
  output stat_event_t                          events,
  output logic [$clog2(MAX_SLOTS+1)-1:0]       rel_amount
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0] held;
  logic [MAX_SLOTS-1:0] held_next;
  logic [ID_W-1:0]      tag [MAX_SLOTS];
  logic [ID_W-1:0]      next_tag;
  logic [ID_W-1:0]      next_tag_next;
  logic [CW-1:0]        held_count;
  logic [CW-1:0]        held_count_next;

  logic [MAX_SLOTS-1:0] active;
  logic [MAX_SLOTS-1:0] free_vec;
  logic [MAX_SLOTS-1:0] match_vec;
  logic [MAX_SLOTS-1:0] freed_vec;
  logic [IW-1:0]        free_idx;
  logic [IW-1:0]        match_idx;
  logic [CW-1:0]        freed_cnt;
  logic                 tag_we;
  logic [IW-1:0]        res_idx;
  logic [IW+2:0]        idx_ext;
  logic [CW+3:0]        count_ext;
  logic [CW+3:0]        freed_ext;
  logic                 res_ok;
  logic [ID_W-1:0]      res_tag;
  logic [CW-1:0]        res_freed;

  // Per-slot qualifiers: active window, free, tag match, held for release-all
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      active[i]    = (32'(i) < 32'(n_active));
      free_vec[i]  = active[i] & ~held[i];
      match_vec[i] = active[i] & held[i] & (tag[i] == id) & (id != '0);
      freed_vec[i] = active[i] & held[i];
    end
  end

  // Lowest set bit of the free and match vectors
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IW'(i);
      end
      if (match_vec[i]) begin
        match_idx = IW'(i);
      end
    end
  end

  assign freed_cnt = CW'($countones(freed_vec));

  // Decide the request and the next state
  always_comb begin
    held_next       = held;
    next_tag_next   = next_tag;
    held_count_next = held_count;
    tag_we          = 1'b0;
    res_ok          = 1'b0;
    res_idx         = '0;
    res_tag         = '0;
    res_freed       = '0;
    events          = '0;
    unique case (req)
      REQ_ACQUIRE: begin
        if (|free_vec) begin
          held_next[free_idx] = 1'b1;
          tag_we              = 1'b1;
          res_tag             = next_tag;
          next_tag_next       = (&next_tag) ? ID_W'(1) : next_tag + ID_W'(1);
          held_count_next     = held_count + CW'(1);
          res_ok              = 1'b1;
          res_idx             = free_idx;
          events.acq          = 1'b1;
        end else begin
          events.drop = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (|match_vec) begin
          held_next[match_idx] = 1'b0;
          held_count_next      = held_count - CW'(1);
          res_ok               = 1'b1;
          res_idx              = match_idx;
          events.rel           = 1'b1;
        end else begin
          events.bad = 1'b1;
        end
      end
      REQ_RELEASE_ALL: begin
        held_next       = held & ~freed_vec;
        held_count_next = held_count - freed_cnt;
        res_freed       = freed_cnt;
        res_ok          = (freed_cnt != '0);
        events.rel      = (freed_cnt != '0);
      end
      default: begin
      end
    endcase
  end

  // A single release frees one slot; release-all frees the counted set
  assign rel_amount = (req == REQ_RELEASE_ALL) ? freed_cnt : CW'(1);

  // Narrow the result fields to their port widths
  assign idx_ext   = {3'b000, res_idx};
  assign count_ext = {4'b0000, held_count_next};
  assign freed_ext = {4'b0000, res_freed};

  always_comb begin
    result.ok          = res_ok;
    result.slot_index  = idx_ext[2:0];
    result.buffer_id   = res_tag;
    result.outstanding = count_ext[3:0];
    result.freed_count = freed_ext[3:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      next_tag   <= ID_W'(1);
      held_count <= '0;
    end else if (en) begin
      held       <= held_next;
      next_tag   <= next_tag_next;
      held_count <= held_count_next;
    end
  end

  // Tags only matter while their slot is held, so they need no reset
  always_ff @(posedge clk) begin
    if (en && tag_we) begin
      tag[free_idx] <= next_tag;
    end
  end

endmodule

FILE: sv/tbp_checker.sv
// Port-level checks for the tagged buffer pool, bound to the top level.
// Depends on tbp_pkg for the channel widths.
module tbp_checker
  import tbp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown straight after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With the output register empty, the block always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while the output is empty");

  // A stamped id is only reported for a successful acquire.
  a_id_needs_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[66:3] != '0) |->
      m_axis_tuser && (m_axis_tdata[74:71] == 4'd0))
    else $error("buffer id reported without a granted slot");

  // Slots reclaimed by release-all always make the result good.
  a_freed_needs_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[74:71] != 4'd0) |-> m_axis_tuser)
    else $error("slots freed without ok");

endmodule

bind tagged_buffer_pool_top tbp_checker u_tbp_checker (.*);
